/* rtl/lace_pkg.sv */
// Shared types, register indexes, constants and helpers of the LED animation color engine.
`default_nettype none

package lace_pkg;

    localparam int unsigned CHAN_W    = 8;
    localparam int unsigned COLOR_W   = 3 * CHAN_W;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned PROD_W    = 18;

    // animation modes
    localparam logic [1:0] MODE_STATIC  = 2'd0;
    localparam logic [1:0] MODE_BREATHE = 2'd1;
    localparam logic [1:0] MODE_BLINK   = 2'd2;
    localparam logic [1:0] MODE_PULSE   = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_EYE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BODY_A = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_BODY_B = 3'd3;

    localparam logic [7:0] BREATHE_STEP = 8'd8;
    localparam logic [7:0] LEVEL_MAX    = 8'd255;
    localparam logic [7:0] SCALE_BASE   = 8'd72;
    localparam logic [7:0] SCALE_SPAN   = 8'd168;

    // controller -> datapath
    typedef struct packed {
        logic accept;   // take item, advance animation state
        logic mul1;     // breathe: delta*level, pulse: s*168
        logic div1;     // breathe: body result, pulse: scale
        logic mul2;     // pulse: a*scale
        logic div2;     // pulse: body result
        logic load;     // move frame into output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic [1:0] mode;
        logic       out_busy;
    } t_stat;

    // floor(x / 255) for x <= 65025, by reciprocal with correction
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] t;
        t = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
        return t[15:8];
    endfunction

endpackage

`default_nettype wire

/* rtl/lace_ctrl.sv */
// Controller state machine sequencing one animation tick through the datapath.
`default_nettype none

module lace_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire lace_pkg::t_stat i_stat,
    output lace_pkg::t_cmd     o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL1 = 6'b000010,
        S_DIV1 = 6'b000100,
        S_MUL2 = 6'b001000,
        S_DIV2 = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_stat.mode == lace_pkg::MODE_BREATHE ||
                        i_stat.mode == lace_pkg::MODE_PULSE) begin
                        n_state = S_MUL1;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end
            S_MUL1: begin
                o_cmd.mul1 = 1'b1;
                n_state    = S_DIV1;
            end
            S_DIV1: begin
                o_cmd.div1 = 1'b1;
                n_state    = (i_stat.mode == lace_pkg::MODE_PULSE) ? S_MUL2 : S_OUT;
            end
            S_MUL2: begin
                o_cmd.mul2 = 1'b1;
                n_state    = S_DIV2;
            end
            S_DIV2: begin
                o_cmd.div2 = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                if (!i_stat.out_busy) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

/* rtl/lace_dp.sv */
// Datapath: registers, animation state, per-channel multipliers and output register.
`default_nettype none

module lace_dp (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire lace_pkg::t_cmd                      i_cmd,
    output lace_pkg::t_stat                          o_stat,
    input  wire logic [7:0]                          i_audio_level,
    input  wire logic                                i_cfg_valid,
    input  wire logic [lace_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [lace_pkg::COLOR_W-1:0]        i_cfg_data,
    input  wire logic                                i_out_ready,
    output logic                                     o_out_valid,
    output logic [lace_pkg::COLOR_W-1:0]             o_eye,
    output logic [lace_pkg::COLOR_W-1:0]             o_body
);

    localparam int unsigned CW = lace_pkg::CHAN_W;

    // configuration
    logic [1:0]                      r_mode;
    logic [lace_pkg::COLOR_W-1:0]    r_eye;
    logic [lace_pkg::COLOR_W-1:0]    r_a;
    logic [lace_pkg::COLOR_W-1:0]    r_b;

    // animation state
    logic [7:0] r_breathe_level;
    logic       r_breathe_rising;
    logic       r_blink_lit;
    logic [7:0] r_smoothed;

    // per-item work registers
    logic                            r_dark;
    logic [7:0]                      r_scale;
    logic signed [lace_pkg::PROD_W-1:0] r_prod [3];
    logic [lace_pkg::COLOR_W-1:0]    r_body;

    // output register
    logic                            r_out_valid;
    logic [lace_pkg::COLOR_W-1:0]    r_out_eye;
    logic [lace_pkg::COLOR_W-1:0]    r_out_body;

    logic       cfg_hit;
    logic [8:0] breathe_up;
    logic [9:0] smooth_sum;

    logic signed [9:0]  mul_a [3];
    logic signed [9:0]  mul_b [3];
    logic signed [19:0] mul_p [3];
    logic               neg   [3];
    logic [16:0]        mag   [3];
    logic [7:0]         quo   [3];
    logic [8:0]         mix   [3];

    assign cfg_hit    = i_cfg_valid && (i_cfg_index == lace_pkg::REG_MODE ||
                                        i_cfg_index == lace_pkg::REG_EYE ||
                                        i_cfg_index == lace_pkg::REG_BODY_A ||
                                        i_cfg_index == lace_pkg::REG_BODY_B);
    assign breathe_up = {1'b0, r_breathe_level} + {1'b0, lace_pkg::BREATHE_STEP};
    assign smooth_sum = {2'b0, r_smoothed} + {1'b0, r_smoothed, 1'b0} + {2'b0, i_audio_level};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (i_cmd.mul2) begin
                mul_a[k] = {2'b0, r_a[lace_pkg::COLOR_W-1-CW*k -: CW]};
                mul_b[k] = {2'b0, r_scale};
            end else if (r_mode == lace_pkg::MODE_PULSE) begin
                mul_a[k] = {2'b0, r_smoothed};
                mul_b[k] = {2'b0, lace_pkg::SCALE_SPAN};
            end else begin
                mul_a[k] = $signed({2'b0, r_b[lace_pkg::COLOR_W-1-CW*k -: CW]})
                         - $signed({2'b0, r_a[lace_pkg::COLOR_W-1-CW*k -: CW]});
                mul_b[k] = {2'b0, r_breathe_level};
            end
            mul_p[k] = mul_a[k] * mul_b[k];
            neg[k]   = r_prod[k][lace_pkg::PROD_W-1];
            mag[k]   = neg[k] ? 17'(-r_prod[k]) : 17'(r_prod[k]);
            quo[k]   = lace_pkg::div255(mag[k][15:0]);
            mix[k]   = neg[k] ? ({1'b0, r_a[lace_pkg::COLOR_W-1-CW*k -: CW]} - {1'b0, quo[k]})
                              : ({1'b0, r_a[lace_pkg::COLOR_W-1-CW*k -: CW]} + {1'b0, quo[k]});
        end
    end

    // configuration and animation state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode           <= lace_pkg::MODE_STATIC;
            r_eye            <= '0;
            r_a              <= '0;
            r_b              <= '0;
            r_breathe_level  <= '0;
            r_breathe_rising <= 1'b1;
            r_blink_lit      <= 1'b0;
            r_smoothed       <= '0;
        end else if (cfg_hit) begin
            unique case (i_cfg_index)
                lace_pkg::REG_MODE:   r_mode <= i_cfg_data[1:0];
                lace_pkg::REG_EYE:    r_eye  <= i_cfg_data;
                lace_pkg::REG_BODY_A: r_a    <= i_cfg_data;
                lace_pkg::REG_BODY_B: r_b    <= i_cfg_data;
                default: ;
            endcase
            r_breathe_level  <= '0;
            r_breathe_rising <= 1'b1;
            r_blink_lit      <= 1'b0;
            r_smoothed       <= '0;
        end else if (i_cmd.accept) begin
            unique case (r_mode)
                lace_pkg::MODE_BREATHE: begin
                    if (r_breathe_rising) begin
                        if (breathe_up >= {1'b0, lace_pkg::LEVEL_MAX}) begin
                            r_breathe_level  <= lace_pkg::LEVEL_MAX;
                            r_breathe_rising <= 1'b0;
                        end else begin
                            r_breathe_level  <= breathe_up[7:0];
                        end
                    end else if (r_breathe_level <= lace_pkg::BREATHE_STEP) begin
                        r_breathe_level  <= '0;
                        r_breathe_rising <= 1'b1;
                    end else begin
                        r_breathe_level  <= r_breathe_level - lace_pkg::BREATHE_STEP;
                    end
                end
                lace_pkg::MODE_BLINK: r_blink_lit <= ~r_blink_lit;
                lace_pkg::MODE_PULSE: r_smoothed  <= smooth_sum[9:2];
                default: ;
            endcase
        end
    end

    // per-item datapath
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_body <= r_a;
            r_dark <= (r_mode == lace_pkg::MODE_BLINK) && r_blink_lit;
        end
        if (i_cmd.mul1 || i_cmd.mul2) begin
            for (int k = 0; k < 3; k++) begin
                r_prod[k] <= mul_p[k][lace_pkg::PROD_W-1:0];
            end
        end
        if (i_cmd.div1) begin
            if (r_mode == lace_pkg::MODE_PULSE) begin
                r_scale <= lace_pkg::SCALE_BASE + quo[0];
            end else begin
                for (int k = 0; k < 3; k++) begin
                    r_body[lace_pkg::COLOR_W-1-CW*k -: CW] <= mix[k][7:0];
                end
            end
        end
        if (i_cmd.div2) begin
            for (int k = 0; k < 3; k++) begin
                r_body[lace_pkg::COLOR_W-1-CW*k -: CW] <= quo[k];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_eye  <= r_dark ? '0 : r_eye;
            r_out_body <= r_dark ? '0 : r_body;
        end
    end

    assign o_stat.mode     = r_mode;
    assign o_stat.out_busy = r_out_valid && !i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_eye           = r_out_eye;
    assign o_body          = r_out_body;

endmodule

`default_nettype wire

/* rtl/led_animation_color_engine_unit.sv */
// Top level of the LED animation color engine: controller plus datapath.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------
//  in      | input     | i_in_valid / o_in_ready    | i_audio_level
//  out     | output    | o_out_valid / i_out_ready  | o_eye_{red,green,blue}, o_body_*
//  cfg     | input     | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One item per tick. Static and blink go through accept and output load;
// breathe adds one multiply and one divide-by-255 step; pulse steps through
// the dependent chain s*168 -> scale -> a*scale -> /255 on the three
// per-channel multipliers. A new item is taken only when the controller is idle.
// Synchronous active-low reset clears mode, colors and animation state.
// A full output register stalls the controller in its load step; the
// register itself holds the frame so the next item can be accepted meanwhile.
// The configuration port is always ready; any write to a known register
// restarts the animation state.
`default_nettype none

module led_animation_color_engine_unit (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // input items
    input  wire logic                              i_in_valid,
    output logic                                   o_in_ready,
    input  wire logic [7:0]                        i_audio_level,
    // result items
    output logic                                   o_out_valid,
    input  wire logic                              i_out_ready,
    output logic [7:0]                             o_eye_red,
    output logic [7:0]                             o_eye_green,
    output logic [7:0]                             o_eye_blue,
    output logic [7:0]                             o_body_red,
    output logic [7:0]                             o_body_green,
    output logic [7:0]                             o_body_blue,
    // configuration writes
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [lace_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [lace_pkg::COLOR_W-1:0]      i_cfg_data
);

    lace_pkg::t_cmd                  cmd;
    lace_pkg::t_stat                 stat;
    logic [lace_pkg::COLOR_W-1:0]    eye;
    logic [lace_pkg::COLOR_W-1:0]    body;

    // sequencing
    lace_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    // arithmetic, state and output register
    lace_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_audio_level (i_audio_level),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_eye         (eye),
        .o_body        (body)
    );

    assign o_cfg_ready  = 1'b1;

    // packed RGB: red 23:16, green 15:8, blue 7:0
    assign o_eye_red    = eye[23:16];
    assign o_eye_green  = eye[15:8];
    assign o_eye_blue   = eye[7:0];
    assign o_body_red   = body[23:16];
    assign o_body_green = body[15:8];
    assign o_body_blue  = body[7:0];

endmodule

`default_nettype wire

/* tb/sv/led_frame_checker.sv */
// Frame checker for the LED animation color engine: predicts each frame and compares results.
module led_frame_checker (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    input  wire logic                           i_in_ready,
    input  wire logic [7:0]                     i_audio_level,
    input  wire logic                           i_out_valid,
    input  wire logic                           i_out_ready,
    input  wire logic [7:0]                     i_eye_red,
    input  wire logic [7:0]                     i_eye_green,
    input  wire logic [7:0]                     i_eye_blue,
    input  wire logic [7:0]                     i_body_red,
    input  wire logic [7:0]                     i_body_green,
    input  wire logic [7:0]                     i_body_blue,
    input  wire logic                           i_cfg_valid,
    input  wire logic                           i_cfg_ready,
    input  wire logic [lace_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [lace_pkg::COLOR_W-1:0]   i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import lace_pkg::*;

    typedef struct packed {
        logic [7:0] eye_r;
        logic [7:0] eye_g;
        logic [7:0] eye_b;
        logic [7:0] body_r;
        logic [7:0] body_g;
        logic [7:0] body_b;
    } t_led_frame;

    // register copies
    logic [1:0]         mode_q;
    logic [COLOR_W-1:0] eye_q;
    logic [COLOR_W-1:0] color_a_q;
    logic [COLOR_W-1:0] color_b_q;

    // animation state
    logic [7:0] breathe_lvl;
    logic       breathe_up;
    logic       blink_dark;
    logic [7:0] smooth_lvl;

    t_led_frame frames_due[$];
    int         failures;

    string field_names[6] = '{"eye_red", "eye_green", "eye_blue",
                              "body_red", "body_green", "body_blue"};

    function automatic int chan_of(logic [COLOR_W-1:0] rgb, int k);
        chan_of = int'(rgb[COLOR_W-1-CHAN_W*k -: CHAN_W]);
    endfunction

    task automatic restart_animation();
        breathe_lvl = '0;
        breathe_up  = 1'b1;
        blink_dark  = 1'b0;
        smooth_lvl  = '0;
    endtask

    // advance the animation by one tick and build its frame
    task automatic compute_frame(input logic [7:0] audio, output t_led_frame frame);
        int         k;
        int         ca;
        int         cb;
        int         lvl;
        int         full;
        int         s;
        int         scale;
        logic [7:0] eye[3];
        logic [7:0] body[3];
        full = int'(LEVEL_MAX);
        for (k = 0; k < 3; k++) begin
            eye[k]  = 8'(chan_of(eye_q, k));
            body[k] = 8'(chan_of(color_a_q, k));
        end
        case (mode_q)
            MODE_BREATHE: begin
                lvl = int'(breathe_lvl);
                if (breathe_up) begin
                    if (lvl + 8 >= full) begin
                        breathe_lvl = LEVEL_MAX;
                        breathe_up  = 1'b0;
                    end else begin
                        breathe_lvl = breathe_lvl + BREATHE_STEP;
                    end
                end else if (lvl <= 8) begin
                    breathe_lvl = '0;
                    breathe_up  = 1'b1;
                end else begin
                    breathe_lvl = breathe_lvl - BREATHE_STEP;
                end
                lvl = int'(breathe_lvl);
                for (k = 0; k < 3; k++) begin
                    ca      = chan_of(color_a_q, k);
                    cb      = chan_of(color_b_q, k);
                    // signed mix, division truncates toward zero
                    body[k] = 8'(ca + ((cb - ca) * lvl) / full);
                end
            end
            MODE_BLINK: begin
                if (blink_dark) begin
                    for (k = 0; k < 3; k++) begin
                        eye[k]  = '0;
                        body[k] = '0;
                    end
                end
                blink_dark = ~blink_dark;
            end
            MODE_PULSE: begin
                s          = int'(smooth_lvl);
                s          = (3 * s + int'(audio)) / 4;
                smooth_lvl = 8'(s);
                scale      = int'(SCALE_BASE) + (s * int'(SCALE_SPAN)) / full;
                for (k = 0; k < 3; k++) begin
                    ca      = chan_of(color_a_q, k);
                    body[k] = 8'((ca * scale) / full);
                end
            end
            default: ;
        endcase
        frame = {eye[0], eye[1], eye[2], body[0], body[1], body[2]};
    endtask

    always @(posedge i_clk) begin : track
        t_led_frame want;
        t_led_frame got;
        int         k;
        bit         bad;
        if (!i_rst_n) begin
            mode_q    = MODE_STATIC;
            eye_q     = '0;
            color_a_q = '0;
            color_b_q = '0;
            restart_animation();
            frames_due.delete();
            failures  = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                // known indexes restart the animation; others are ignored
                case (i_cfg_index)
                    REG_MODE:   begin mode_q    = i_cfg_data[1:0]; restart_animation(); end
                    REG_EYE:    begin eye_q     = i_cfg_data;      restart_animation(); end
                    REG_BODY_A: begin color_a_q = i_cfg_data;      restart_animation(); end
                    REG_BODY_B: begin color_b_q = i_cfg_data;      restart_animation(); end
                    default: ;
                endcase
            end
            // pop before push: a result never belongs to the item taken at the same edge
            if (i_out_valid && i_out_ready) begin
                got = {i_eye_red, i_eye_green, i_eye_blue,
                       i_body_red, i_body_green, i_body_blue};
                if (frames_due.size() == 0) begin
                    if (failures < 10)
                        $display("ERROR: frame %h with no frame outstanding", got);
                    failures++;
                end else begin
                    want = frames_due.pop_front();
                    bad  = 1'b0;
                    for (k = 0; k < 6; k++) begin
                        if (got[47-8*k -: 8] !== want[47-8*k -: 8]) begin
                            if (failures < 10)
                                $display("ERROR: %s expected %h got %h", field_names[k],
                                         want[47-8*k -: 8], got[47-8*k -: 8]);
                            bad = 1'b1;
                        end
                    end
                    if (bad)
                        failures++;
                end
            end
            if (i_in_valid && i_in_ready) begin
                compute_frame(i_audio_level, want);
                frames_due.push_back(want);
            end
        end
        o_fail_count <= failures;
        o_pending    <= frames_due.size();
    end

endmodule

/* tb/sv/tb_led_animation_color_engine_unit.sv */
// Testbench top for the LED animation color engine: stimulus, idling, watchdog and verdict.
module tb_led_animation_color_engine_unit;
    import lace_pkg::*;

    localparam int RANDOM_TICKS   = 1200;
    localparam int QUIET_LIMIT    = 2000;  // cycles with no handshake before giving up
    localparam int LONG_HOLD      = 150;   // receiver hold-off for the back-pressure burst
    localparam int SETTLE_CYCLES  = 8;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_LO = REG_BODY_B + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED_HI = '1;

    typedef struct {
        logic [CFG_IDX_W-1:0] idx;
        logic [COLOR_W-1:0]   data;
    } t_reg_write;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_ready;
    logic [7:0]           i_audio_level;
    logic                 o_out_valid;
    logic                 i_out_ready;
    logic [7:0]           o_eye_red;
    logic [7:0]           o_eye_green;
    logic [7:0]           o_eye_blue;
    logic [7:0]           o_body_red;
    logic [7:0]           o_body_green;
    logic [7:0]           o_body_blue;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [COLOR_W-1:0]   i_cfg_data;

    int  fail_count;
    int  frames_outstanding;

    // sender-side bookkeeping
    t_reg_write writes_queued[$];
    bit         source_gaps_on;
    int         ticks_sent;
    int         reg_writes;
    int         unused_writes;
    int         settings_run;

    // receiver-side bookkeeping
    bit         sink_gaps_on;
    logic       hold_req;   // toggled by the sender to ask for one long hold-off
    int         frames_taken;

    led_animation_color_engine_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_audio_level (i_audio_level),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_eye_red     (o_eye_red),
        .o_eye_green   (o_eye_green),
        .o_eye_blue    (o_eye_blue),
        .o_body_red    (o_body_red),
        .o_body_green  (o_body_green),
        .o_body_blue   (o_body_blue),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    led_frame_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_ready    (o_in_ready),
        .i_audio_level (i_audio_level),
        .i_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .i_eye_red     (o_eye_red),
        .i_eye_green   (o_eye_green),
        .i_eye_blue    (o_eye_blue),
        .i_body_red    (o_body_red),
        .i_body_green  (o_body_green),
        .i_body_blue   (o_body_blue),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_fail_count  (fail_count),
        .o_pending     (frames_outstanding)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Colors lean on the extremes: black, white, or anything.
    function automatic logic [COLOR_W-1:0] pick_color();
        case ($urandom_range(0, 3))
            0:       pick_color = '0;
            1:       pick_color = '1;
            default: pick_color = COLOR_W'($urandom);
        endcase
    endfunction

    // Offer one tick. Valid is only dropped when a gap is drawn, so a
    // back-to-back item never sees valid lowered and raised in one step.
    task automatic send_tick(input logic [7:0] level);
        int gap;
        gap = source_gaps_on ? $urandom_range(0, 7) : 0;
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_audio_level <= level;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        ticks_sent++;
    endtask

    // Stop offering ticks and wait until every frame has been taken.
    task automatic drain_frames();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (frames_outstanding != 0) @(posedge i_clk);
    endtask

    task automatic queue_write(input logic [CFG_IDX_W-1:0] idx,
                               input logic [COLOR_W-1:0] data);
        t_reg_write w;
        w.idx  = idx;
        w.data = data;
        writes_queued.push_back(w);
    endtask

    // Registers change only with the engine idle: drain first, then write.
    task automatic apply_writes();
        t_reg_write w;
        drain_frames();
        while (writes_queued.size() != 0) begin
            w = writes_queued.pop_front();
            i_cfg_valid <= 1'b1;
            i_cfg_index <= w.idx;
            i_cfg_data  <= w.data;
            do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
            reg_writes++;
            if (w.idx >= REG_UNUSED_LO)
                unused_writes++;
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic queue_unused_write();
        queue_write(CFG_IDX_W'($urandom_range(REG_UNUSED_LO, REG_UNUSED_HI)), pick_color());
    endtask

    // Full reprogram; upper bits of the mode word are noise the block must mask.
    task automatic program_mode(input logic [1:0] mode, input logic [COLOR_W-1:0] eye,
                                input logic [COLOR_W-1:0] col_a,
                                input logic [COLOR_W-1:0] col_b);
        if ($urandom_range(0, 4) == 0)
            queue_unused_write();
        queue_write(REG_MODE, (COLOR_W'($urandom) & ~COLOR_W'(3)) | COLOR_W'(mode));
        queue_write(REG_EYE, eye);
        queue_write(REG_BODY_A, col_a);
        queue_write(REG_BODY_B, col_b);
        apply_writes();
        settings_run++;
    endtask

    // Audio levels: pure noise, a held value, or slamming between the extremes.
    function automatic logic [7:0] pick_level(input int style, input logic [7:0] held);
        case (style)
            0:       pick_level = 8'($urandom);
            1:       pick_level = held;
            default: pick_level = $urandom_range(0, 1) ? 8'hFF : 8'h00;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Receiver: random stall per frame, quiet stretches, and one long
    // hold-off on request so the engine backs up into its input.
    // ------------------------------------------------------------------
    initial begin : frame_sink
        int   stall;
        logic hold_ack;
        hold_ack     = 1'b0;
        sink_gaps_on = 1'b1;
        frames_taken = 0;
        i_out_ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_req !== hold_ack) begin
                hold_ack = hold_req;
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
            end
            stall = sink_gaps_on ? $urandom_range(0, 7) : 0;
            if (stall != 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
            frames_taken++;
            if (frames_taken % 50 == 0)
                sink_gaps_on = ($urandom_range(0, 3) != 0);
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: any handshake resets the count; a long silence is a hang.
    // ------------------------------------------------------------------
    initial begin : hang_watch
        int quiet;
        quiet = 0;
        wait (i_rst_n === 1'b1);
        do begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end while (quiet < QUIET_LIMIT);
        $display("ERROR: no handshake for %0d cycles", QUIET_LIMIT);
        $display("led_animation_color_engine_unit verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial begin : tick_source
        int         i;
        int         n;
        int         style;
        int         random_ticks;
        logic [1:0] mode;
        logic [7:0] held;

        i_rst_n        <= 1'b0;
        i_in_valid     <= 1'b0;
        i_audio_level  <= '0;
        i_cfg_valid    <= 1'b0;
        i_cfg_index    <= '0;
        i_cfg_data     <= '0;
        hold_req       <= 1'b0;
        source_gaps_on  = 1'b1;
        ticks_sent      = 0;
        reg_writes      = 0;
        unused_writes   = 0;
        settings_run    = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // ---- directed part ----
        // Reset defaults: static mode, all colors black.
        send_tick(8'h00);
        send_tick(8'hFF);

        // Static with white eye, black body.
        program_mode(MODE_STATIC, '1, '0, '1);
        send_tick(8'hFF);

        // Breathe toward a color below body A in two channels (negative mix).
        program_mode(MODE_BREATHE, 24'h00FF00, 24'hFF00FF, 24'h00FF00);
        repeat (3) send_tick(8'h00);

        // Blink: lit, dark, lit.
        program_mode(MODE_BLINK, 24'h123456, '1, '0);
        repeat (3) send_tick(8'hFF);

        // Pulse: full level, full level, then silence.
        program_mode(MODE_PULSE, '0, '1, '0);
        send_tick(8'hFF);
        send_tick(8'hFF);
        send_tick(8'h00);

        // A write to an unused index must leave the smoothed level alone.
        queue_write(REG_UNUSED_HI, '1);
        apply_writes();
        send_tick(8'hFF);

        // A write to an unused-in-this-mode register still restarts everything.
        queue_write(REG_BODY_B, 24'hA5A5A5);
        apply_writes();
        send_tick(8'hFF);
        send_tick(8'h80);

        // ---- back-pressure burst ----
        // Receiver holds off for a long stretch while ticks keep coming with
        // no gaps, so the output register fills and input ready drops.
        program_mode(MODE_BREATHE, pick_color(), '0, '1);
        source_gaps_on = 1'b0;
        hold_req <= ~hold_req;
        repeat (24) send_tick(8'($urandom));
        // Sender pauses until every frame is out.
        drain_frames();
        source_gaps_on = 1'b1;

        // ---- random part ----
        random_ticks = 0;
        while (random_ticks < RANDOM_TICKS) begin
            mode = 2'($urandom_range(0, 3));
            program_mode(mode, pick_color(), pick_color(), pick_color());
            source_gaps_on = ($urandom_range(0, 3) != 0);
            // breathe needs long phases to reach the top and come back down
            n     = (mode == MODE_BREATHE) ? $urandom_range(20, 120) : $urandom_range(5, 60);
            style = $urandom_range(0, 2);
            held  = 8'($urandom);
            for (i = 0; i < n; i++) begin
                if ($urandom_range(0, 39) == 0) begin
                    case ($urandom_range(0, 2))
                        0:       queue_unused_write();
                        1:       queue_write(CFG_IDX_W'($urandom_range(REG_EYE, REG_BODY_B)),
                                             pick_color());
                        default: queue_write(REG_MODE, COLOR_W'($urandom));
                    endcase
                    apply_writes();
                end
                send_tick(pick_level(style, held));
                random_ticks++;
            end
        end

        // ---- wind down ----
        drain_frames();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Covered %0d ticks over %0d settings of all four modes, %0d frames checked,",
                 ticks_sent, settings_run, frames_taken);
        $display("with %0d register writes (%0d to unused indexes) and a long output stall.",
                 reg_writes, unused_writes);
        if (fail_count == 0 && frames_outstanding == 0)
            $display("led_animation_color_engine_unit verification clean");
        else
            $display("led_animation_color_engine_unit verification failed");
        $finish;
    end

endmodule
